// File: rtl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types, constants and the byte-wide CRC-16 step for the
// length-prefixed frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

    // Largest payload a frame may carry
    localparam int MAX_PAYLOAD = 64;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

    // Configuration register indexes
    localparam logic [1:0] CFG_HEADER  = 2'd0;
    localparam logic [1:0] CFG_POLY    = 2'd1;
    localparam logic [1:0] CFG_START   = 2'd2;
    localparam logic [1:0] CFG_REFLECT = 2'd3;

    // Register reset values
    localparam logic [7:0]  HEADER_RST = 8'hFD;
    localparam logic [15:0] POLY_RST   = 16'h1021;
    localparam logic [15:0] START_RST  = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_LENGTH,
        ST_PAYLOAD,
        ST_CRC_LO,
        ST_CRC_HI,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } t_cfd_state;

    // Controller -> datapath
    typedef struct packed {
        logic len_load;
        logic pay_write;
        logic crc_lo_load;
        logic emit_start;
        logic emit_push;
    } t_cfd_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic hdr_match;
        logic len_ok;
        logic pay_done;
        logic crc_ok;
        logic emit_last;
        logic out_free;
    } t_cfd_sts;

    // One byte through the CRC-16 register, MSB-first or LSB-first
    function automatic logic [15:0] crc16_byte(
        input logic [15:0] crc,
        input logic [7:0]  data,
        input logic [15:0] poly,
        input logic        reflect
    );
        logic [15:0] c;
        c = reflect ? (crc ^ {8'h00, data}) : (crc ^ {data, 8'h00});
        for (int i = 0; i < 8; i++) begin
            if (reflect) begin
                c = c[0] ? ({1'b0, c[15:1]} ^ poly) : {1'b0, c[15:1]};
            end else begin
                c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/cfd_ctrl.sv
// ----------------------------------------------------------------------------
// cfd_ctrl
// Frame state machine: hunts for the header, walks length, payload and
// CRC bytes, then sequences the readout of an accepted frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_ctrl
    import cfd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_cfd_sts i_sts,
    output t_cfd_cmd      o_cmd
);

    t_cfd_state r_state;
    t_cfd_state n_state;
    logic       w_acc;

    assign w_acc = i_in_valid & o_in_ready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_HUNT: begin
                if (w_acc && i_sts.hdr_match) n_state = ST_LENGTH;
            end
            ST_LENGTH: begin
                if (w_acc) n_state = i_sts.len_ok ? ST_PAYLOAD : ST_HUNT;
            end
            ST_PAYLOAD: begin
                if (w_acc && i_sts.pay_done) n_state = ST_CRC_LO;
            end
            ST_CRC_LO: begin
                if (w_acc) n_state = ST_CRC_HI;
            end
            ST_CRC_HI: begin
                if (w_acc) n_state = i_sts.crc_ok ? ST_EMIT_RD : ST_HUNT;
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (i_sts.out_free) n_state = i_sts.emit_last ? ST_HUNT : ST_EMIT_RD;
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_HUNT: begin
                o_in_ready = 1'b1;
            end
            ST_LENGTH: begin
                o_in_ready     = 1'b1;
                o_cmd.len_load = i_in_valid & i_sts.len_ok;
            end
            ST_PAYLOAD: begin
                o_in_ready      = 1'b1;
                o_cmd.pay_write = i_in_valid;
            end
            ST_CRC_LO: begin
                o_in_ready        = 1'b1;
                o_cmd.crc_lo_load = i_in_valid;
            end
            ST_CRC_HI: begin
                o_in_ready       = 1'b1;
                o_cmd.emit_start = i_in_valid & i_sts.crc_ok;
            end
            ST_EMIT_RD: begin
                o_in_ready = 1'b0;
            end
            ST_EMIT_OUT: begin
                o_cmd.emit_push = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A bad CRC drops the frame straight back to hunting
    a_crc_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CRC_HI && w_acc && !i_sts.crc_ok) |=> (r_state == ST_HUNT))
        else $error("frame with bad CRC not dropped");

    // Memory read latency: every read slot is followed by an output slot
    a_rd_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_RD) |=> (r_state == ST_EMIT_OUT))
        else $error("emit read not followed by output");

    // A good length byte always opens the payload phase
    a_len_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LENGTH && w_acc && i_sts.len_ok) |=> (r_state == ST_PAYLOAD))
        else $error("valid length did not start payload");
`endif

endmodule

`default_nettype wire

// File: rtl/cfd_dpath.sv
// ----------------------------------------------------------------------------
// cfd_dpath
// Configuration registers, running CRC, payload store and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_dpath
    import cfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic [7:0]  i_byte,
    input  wire t_cfd_cmd    i_cmd,
    output t_cfd_sts         o_sts,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic [6:0]       o_out_len,
    output logic             o_out_last
);

    logic [7:0]       r_header;
    logic [15:0]      r_poly;
    logic [15:0]      r_start;
    logic             r_reflect;
    logic [15:0]      r_crc;
    logic [7:0]       r_crc_lo;
    logic [CNT_W-1:0] r_frame_len;
    logic [CNT_W-1:0] r_byte_cnt;
    logic [CNT_W-1:0] r_rd_cnt;
    logic [7:0]       r_mem [MAX_PAYLOAD];
    logic [7:0]       r_rd_data;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic [6:0]       r_out_len;
    logic             r_out_last;
    logic [CNT_W-1:0] w_byte_cnt_inc;
    logic [CNT_W-1:0] w_rd_cnt_inc;
    logic [15:0]      w_crc_in;
    logic [15:0]      w_crc_next;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= HEADER_RST;
            r_poly    <= POLY_RST;
            r_start   <= START_RST;
            r_reflect <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEADER:  r_header  <= i_cfg_data[7:0];
                CFG_POLY:    r_poly    <= i_cfg_data;
                CFG_START:   r_start   <= i_cfg_data;
                CFG_REFLECT: r_reflect <= i_cfg_data[0];
                default:     r_header  <= r_header;
            endcase
        end
    end

    // CRC step: length byte starts from the seed, payload bytes chain
    assign w_crc_in   = i_cmd.len_load ? r_start : r_crc;
    assign w_crc_next = crc16_byte(w_crc_in, i_byte, r_poly, r_reflect);

    assign w_byte_cnt_inc = r_byte_cnt + CNT_W'(1);
    assign w_rd_cnt_inc   = r_rd_cnt + CNT_W'(1);

    // Frame bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= '0;
            r_crc_lo    <= '0;
            r_frame_len <= '0;
            r_byte_cnt  <= '0;
            r_rd_cnt    <= '0;
        end else begin
            if (i_cmd.len_load) begin
                r_crc       <= w_crc_next;
                r_frame_len <= i_byte[CNT_W-1:0];
                r_byte_cnt  <= '0;
            end
            if (i_cmd.pay_write) begin
                r_crc      <= w_crc_next;
                r_byte_cnt <= w_byte_cnt_inc;
            end
            if (i_cmd.crc_lo_load) r_crc_lo <= i_byte;
            if (i_cmd.emit_start) begin
                r_rd_cnt <= '0;
            end else if (i_cmd.emit_push) begin
                r_rd_cnt <= w_rd_cnt_inc;
            end
        end
    end

    // Payload store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.pay_write) r_mem[r_byte_cnt[ADDR_W-1:0]] <= i_byte;
        r_rd_data <= r_mem[r_rd_cnt[ADDR_W-1:0]];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_push) begin
            r_out_byte <= r_rd_data;
            r_out_len  <= 7'(r_frame_len);
            r_out_last <= (w_rd_cnt_inc == r_frame_len);
        end
    end

    // Status
    assign o_sts.hdr_match = (i_byte == r_header);
    assign o_sts.len_ok    = (i_byte != 8'd0) && (i_byte <= 8'(MAX_PAYLOAD));
    assign o_sts.pay_done  = (w_byte_cnt_inc >= r_frame_len);
    assign o_sts.crc_ok    = (r_crc == {i_byte, r_crc_lo});
    assign o_sts.emit_last = (w_rd_cnt_inc == r_frame_len);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_len   = r_out_len;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

// File: rtl/crc16_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// crc16_frame_deframer_top
// Length-prefixed frame deframer with CRC-16 check.
// ----------------------------------------------------------------------------
// Takes one received byte per item: header byte, length byte (1..64), that
// many payload bytes, then CRC low and high bytes. The CRC (polynomial,
// seed and bit order set over the config port) covers the length and
// payload bytes. While a frame is being received one byte is accepted every
// cycle. When the CRC matches, the payload is sent out as items of
// {frame length, byte} with tlast on the final byte; the readout goes
// through the registered read port of the 64-byte payload memory, with a
// read state and an output state per byte, and no input is accepted during
// it; the output state waits while the output side stalls. Frames
// with a bad CRC or a bad length are dropped without output.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_frame_deframer_top
    import cfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // received bytes
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // accepted payload
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] payload_byte, [14:8] frame_length
    output logic             m_axis_tlast    // is_last
);

    t_cfd_cmd   w_cmd;
    t_cfd_sts   w_sts;
    logic [7:0] w_out_byte;
    logic [6:0] w_out_len;

    cfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cfd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_byte      (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (w_out_byte),
        .o_out_len   (w_out_len),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_out_len, w_out_byte};

endmodule

`default_nettype wire
